// ===== sv/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// Grayscale dilation argmax package
// Shared types, command and register codes, defaults and helper functions.
// ----------------------------------------------------------------------------
package gda_pkg;

    // Default maximum sizes, handed to the top level as parameter defaults.
    localparam int MAX_IN_CHANNELS_DEF  = 4;
    localparam int MAX_OUT_CHANNELS_DEF = 4;
    localparam int MAX_KERNEL_ROWS_DEF  = 8;
    localparam int MAX_KERNEL_COLS_DEF  = 8;
    localparam int MAX_IMAGE_ROWS_DEF   = 64;
    localparam int MAX_IMAGE_COLS_DEF   = 64;

    // Request commands.
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_QUERY       = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CHANNELS_IN = 3'd0;
    localparam logic [2:0] REG_KERNEL_ROWS = 3'd1;
    localparam logic [2:0] REG_KERNEL_COLS = 3'd2;
    localparam logic [2:0] REG_IMAGE_ROWS  = 3'd3;
    localparam logic [2:0] REG_IMAGE_COLS  = 3'd4;
    localparam logic [2:0] REG_ORIGIN_ROW  = 3'd5;
    localparam logic [2:0] REG_ORIGIN_COL  = 3'd6;
    localparam logic [2:0] REG_PAD_VALUE   = 3'd7;

    // Register reset values.
    localparam logic [2:0]  RST_CHANNELS_IN = 3'd1;
    localparam logic [3:0]  RST_KERNEL_ROWS = 4'd3;
    localparam logic [3:0]  RST_KERNEL_COLS = 4'd3;
    localparam logic [6:0]  RST_IMAGE_ROWS  = 7'd64;
    localparam logic [6:0]  RST_IMAGE_COLS  = 7'd64;
    localparam logic [2:0]  RST_ORIGIN_ROW  = 3'd1;
    localparam logic [2:0]  RST_ORIGIN_COL  = 3'd1;
    localparam logic [15:0] RST_PAD_VALUE   = 16'h8000;

    // Tap index reported when no sum beats the pad value.
    localparam logic [8:0] NO_TAP = 9'h1FF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Address width of a memory of the given depth.
    function automatic int f_addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Size registers saturate into 1..hi; zero acts as one.
    function automatic int f_clamp(input int v, input int hi);
        if (v < 1) begin
            return 1;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

// ===== sv/gda_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = gda_pkg::f_addr_width(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/grayscale_dilation_argmax_top.sv =====
// ----------------------------------------------------------------------------
// Grayscale dilation with argmax
// Multi-channel weighted grayscale dilation over a weight memory and an
// image memory, answering one output pixel per query request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A weight or sample
// load writes its memory in that cycle and leaves busy low, so loads can be
// issued every cycle. A query raises busy and walks every in-channel and
// kernel tap, one tap per cycle, reading the image and weight memories in
// parallel; the sum of sample and weight is compared in the next cycle.
// A query walks every tap and then passes a drain state before the result,
// which is shown for one cycle with o_done. The tap walk through the two
// single-read memories sets the query time. A query outside the output
// answers in the cycle after it is taken. busy falls after the result cycle.
// The receiver cannot stall: o_done flags each result for one cycle only.
// The APB port writes the size, origin and pad registers; the user must
// write them only while idle; the block itself does not enforce this. Reset
// restores their defaults. The memories are not cleared by reset and must
// be loaded before they are queried.
// ----------------------------------------------------------------------------
module grayscale_dilation_argmax_top #(
    parameter int MAX_IN_CHANNELS  = gda_pkg::MAX_IN_CHANNELS_DEF,
    parameter int MAX_OUT_CHANNELS = gda_pkg::MAX_OUT_CHANNELS_DEF,
    parameter int MAX_KERNEL_ROWS  = gda_pkg::MAX_KERNEL_ROWS_DEF,
    parameter int MAX_KERNEL_COLS  = gda_pkg::MAX_KERNEL_COLS_DEF,
    parameter int MAX_IMAGE_ROWS   = gda_pkg::MAX_IMAGE_ROWS_DEF,
    parameter int MAX_IMAGE_COLS   = gda_pkg::MAX_IMAGE_COLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [1:0]         i_out_channel,
    input  logic [1:0]         i_in_channel,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [15:0] i_value,
    // result channel
    output logic               o_done,
    output logic [1:0]         o_result_channel,
    output logic [5:0]         o_result_row,
    output logic [5:0]         o_result_col,
    output logic signed [16:0] o_max_value,
    output logic signed [8:0]  o_best_tap,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL_ROWS
                            * MAX_KERNEL_COLS;
    localparam int IDEPTH = MAX_IN_CHANNELS * MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
    localparam int WAW    = gda_pkg::f_addr_width(WDEPTH);
    localparam int IAW    = gda_pkg::f_addr_width(IDEPTH);
    localparam int CIW    = gda_pkg::f_addr_width(MAX_IN_CHANNELS);
    localparam int KRW    = gda_pkg::f_addr_width(MAX_KERNEL_ROWS);
    localparam int KCW    = gda_pkg::f_addr_width(MAX_KERNEL_COLS);
    localparam int NTAPS  = MAX_IN_CHANNELS * MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int FLW    = $clog2(NTAPS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  r_chan;
    logic [3:0]  r_krows;
    logic [3:0]  r_kcols;
    logic [6:0]  r_irows;
    logic [6:0]  r_icols;
    logic [2:0]  r_orow;
    logic [2:0]  r_ocol;
    logic [15:0] r_pad;
    logic        s_cfg_we;
    logic [2:0]  s_cfg_idx;

    assign pready    = 1'b1;
    assign s_cfg_we  = psel && penable && pwrite && pready;
    assign s_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= gda_pkg::RST_CHANNELS_IN;
            r_krows <= gda_pkg::RST_KERNEL_ROWS;
            r_kcols <= gda_pkg::RST_KERNEL_COLS;
            r_irows <= gda_pkg::RST_IMAGE_ROWS;
            r_icols <= gda_pkg::RST_IMAGE_COLS;
            r_orow  <= gda_pkg::RST_ORIGIN_ROW;
            r_ocol  <= gda_pkg::RST_ORIGIN_COL;
            r_pad   <= gda_pkg::RST_PAD_VALUE;
        end else if (s_cfg_we) begin
            case (s_cfg_idx)
                gda_pkg::REG_CHANNELS_IN: begin
                    r_chan <= 3'(gda_pkg::f_clamp(int'(pwdata[2:0]), MAX_IN_CHANNELS));
                end
                gda_pkg::REG_KERNEL_ROWS: begin
                    r_krows <= 4'(gda_pkg::f_clamp(int'(pwdata[3:0]), MAX_KERNEL_ROWS));
                end
                gda_pkg::REG_KERNEL_COLS: begin
                    r_kcols <= 4'(gda_pkg::f_clamp(int'(pwdata[3:0]), MAX_KERNEL_COLS));
                end
                gda_pkg::REG_IMAGE_ROWS: begin
                    r_irows <= 7'(gda_pkg::f_clamp(int'(pwdata[6:0]), MAX_IMAGE_ROWS));
                end
                gda_pkg::REG_IMAGE_COLS: begin
                    r_icols <= 7'(gda_pkg::f_clamp(int'(pwdata[6:0]), MAX_IMAGE_COLS));
                end
                gda_pkg::REG_ORIGIN_ROW: begin
                    r_orow <= pwdata[2:0];
                end
                gda_pkg::REG_ORIGIN_COL: begin
                    r_ocol <= pwdata[2:0];
                end
                gda_pkg::REG_PAD_VALUE: begin
                    r_pad <= pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (s_cfg_idx)
            gda_pkg::REG_CHANNELS_IN: prdata = {29'd0, r_chan};
            gda_pkg::REG_KERNEL_ROWS: prdata = {28'd0, r_krows};
            gda_pkg::REG_KERNEL_COLS: prdata = {28'd0, r_kcols};
            gda_pkg::REG_IMAGE_ROWS:  prdata = {25'd0, r_irows};
            gda_pkg::REG_IMAGE_COLS:  prdata = {25'd0, r_icols};
            gda_pkg::REG_ORIGIN_ROW:  prdata = {29'd0, r_orow};
            gda_pkg::REG_ORIGIN_COL:  prdata = {29'd0, r_ocol};
            gda_pkg::REG_PAD_VALUE:   prdata = {16'd0, r_pad};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    gda_pkg::t_state r_state;
    gda_pkg::t_state n_state;

    logic s_accept;
    logic s_wgt_we;
    logic s_img_we;
    logic s_query;
    logic s_query_in;
    logic s_scan;

    assign s_accept = start && !busy;
    assign s_wgt_we = s_accept && (i_command == gda_pkg::CMD_LOAD_WEIGHT)
                      && (int'(i_out_channel) < MAX_OUT_CHANNELS)
                      && (int'(i_in_channel) < MAX_IN_CHANNELS)
                      && (int'(i_row) < MAX_KERNEL_ROWS)
                      && (int'(i_col) < MAX_KERNEL_COLS);
    assign s_img_we = s_accept && (i_command == gda_pkg::CMD_LOAD_SAMPLE)
                      && (int'(i_in_channel) < MAX_IN_CHANNELS)
                      && (int'(i_row) < MAX_IMAGE_ROWS)
                      && (int'(i_col) < MAX_IMAGE_COLS);
    assign s_query    = s_accept && (i_command == gda_pkg::CMD_QUERY);
    assign s_query_in = (int'(i_out_channel) < MAX_OUT_CHANNELS)
                        && ({1'b0, i_row} < r_irows) && ({1'b0, i_col} < r_icols);

    logic [WAW-1:0] s_wgt_waddr;
    logic [IAW-1:0] s_img_waddr;

    assign s_wgt_waddr = WAW'(((int'(i_out_channel) * MAX_IN_CHANNELS + int'(i_in_channel))
                               * MAX_KERNEL_ROWS + int'(i_row)) * MAX_KERNEL_COLS
                              + int'(i_col));
    assign s_img_waddr = IAW'((int'(i_in_channel) * MAX_IMAGE_ROWS + int'(i_row))
                              * MAX_IMAGE_COLS + int'(i_col));

    // ------------------------------------------------------------------
    // Tap walk: counters in the order channel, tap row, tap column
    // ------------------------------------------------------------------
    logic [1:0]     r_q_oc;
    logic [5:0]     r_q_row;
    logic [5:0]     r_q_col;
    logic [CIW-1:0] r_ci;
    logic [KRW-1:0] r_kh;
    logic [KCW-1:0] r_kw;
    logic [FLW-1:0] r_flat;
    logic           s_kw_last;
    logic           s_kh_last;
    logic           s_ci_last;
    logic           s_walk_end;

    assign s_kw_last  = (int'(r_kw) == int'(r_kcols) - 1);
    assign s_kh_last  = (int'(r_kh) == int'(r_krows) - 1);
    assign s_ci_last  = (int'(r_ci) == int'(r_chan) - 1);
    assign s_walk_end = s_kw_last && s_kh_last && s_ci_last;

    // Shifted pixel position; a set top bit means it fell above or left.
    logic [11:0] s_hi;
    logic [11:0] s_wi;
    logic        s_tap_in;

    assign s_hi     = 12'(r_q_row) + 12'(r_kh) - 12'(r_orow);
    assign s_wi     = 12'(r_q_col) + 12'(r_kw) - 12'(r_ocol);
    assign s_tap_in = !s_hi[11] && !s_wi[11]
                      && (s_hi < 12'(r_irows)) && (s_wi < 12'(r_icols));

    logic [WAW-1:0] s_wgt_raddr;
    logic [IAW-1:0] s_img_raddr;

    assign s_wgt_raddr = WAW'(((int'(r_q_oc) * MAX_IN_CHANNELS + int'(r_ci))
                               * MAX_KERNEL_ROWS + int'(r_kh)) * MAX_KERNEL_COLS
                              + int'(r_kw));
    assign s_img_raddr = IAW'((int'(r_ci) * MAX_IMAGE_ROWS + int'(s_hi))
                              * MAX_IMAGE_COLS + int'(s_wi));

    logic [15:0] s_wgt_rdata;
    logic [15:0] s_img_rdata;

    gda_ram #(
        .WIDTH (16),
        .DEPTH (WDEPTH),
        .AW    (WAW)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (s_wgt_we),
        .i_waddr (s_wgt_waddr),
        .i_wdata (i_value),
        .i_raddr (s_wgt_raddr),
        .o_rdata (s_wgt_rdata)
    );

    gda_ram #(
        .WIDTH (16),
        .DEPTH (IDEPTH),
        .AW    (IAW)
    ) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (s_img_we),
        .i_waddr (s_img_waddr),
        .i_wdata (i_value),
        .i_raddr (s_img_raddr),
        .o_rdata (s_img_rdata)
    );

    // ------------------------------------------------------------------
    // Compare stage, in the cycle after each walk step
    // ------------------------------------------------------------------
    logic               r_rd_vld;
    logic [FLW-1:0]     r_rd_tap;
    logic signed [16:0] r_best;
    logic [8:0]         r_tap;
    logic signed [16:0] s_sum;
    logic               s_win;

    assign s_sum = 17'($signed(s_img_rdata)) + 17'($signed(s_wgt_rdata));
    assign s_win = r_rd_vld && (s_sum > r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= s_scan && s_tap_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tap <= r_flat;
        if (s_query) begin
            r_q_oc  <= i_out_channel;
            r_q_row <= i_row;
            r_q_col <= i_col;
            r_ci    <= '0;
            r_kh    <= '0;
            r_kw    <= '0;
            r_flat  <= '0;
            r_best  <= 17'($signed(r_pad));
            r_tap   <= gda_pkg::NO_TAP;
        end else begin
            if (s_scan) begin
                r_flat <= r_flat + FLW'(1);
                if (s_kw_last) begin
                    r_kw <= '0;
                    if (s_kh_last) begin
                        r_kh <= '0;
                        r_ci <= r_ci + CIW'(1);
                    end else begin
                        r_kh <= r_kh + KRW'(1);
                    end
                end else begin
                    r_kw <= r_kw + KCW'(1);
                end
            end
            if (s_win) begin
                r_best <= s_sum;
                r_tap  <= 9'(r_rd_tap);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gda_pkg::ST_IDLE: begin
                if (s_query) begin
                    n_state = s_query_in ? gda_pkg::ST_SCAN : gda_pkg::ST_DONE;
                end
            end
            gda_pkg::ST_SCAN: begin
                if (s_walk_end) begin
                    n_state = gda_pkg::ST_DRAIN;
                end
            end
            gda_pkg::ST_DRAIN: begin
                n_state = gda_pkg::ST_DONE;
            end
            gda_pkg::ST_DONE: begin
                n_state = gda_pkg::ST_IDLE;
            end
            default: begin
                n_state = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        s_scan = 1'b0;
        o_done = 1'b0;
        case (r_state)
            gda_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            gda_pkg::ST_SCAN: begin
                s_scan = 1'b1;
            end
            gda_pkg::ST_DRAIN: begin
            end
            gda_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_result_channel = r_q_oc;
    assign o_result_row     = r_q_row;
    assign o_result_col     = r_q_col;
    assign o_max_value      = r_best;
    assign o_best_tap       = r_tap;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Grayscale dilation argmax testbench
// Fills the part of both memories that queries can reach, runs directed
// corner cases and then random load and query traffic under several register
// settings. An in-house model of the dilation predicts every query answer,
// which is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The package names no code for the spare command value.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int N_OUT  = gda_pkg::MAX_OUT_CHANNELS_DEF;
    localparam int N_IN   = gda_pkg::MAX_IN_CHANNELS_DEF;
    localparam int N_KROW = gda_pkg::MAX_KERNEL_ROWS_DEF;
    localparam int N_KCOL = gda_pkg::MAX_KERNEL_COLS_DEF;
    localparam int N_IROW = gda_pkg::MAX_IMAGE_ROWS_DEF;
    localparam int N_ICOL = gda_pkg::MAX_IMAGE_COLS_DEF;

    // Region written before the first query. Random settings never let a
    // query read outside it, so no memory entry is read before it is written.
    localparam int FILL_CH  = N_IN;
    localparam int FILL_K   = 3;
    localparam int FILL_IMG = 6;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEMS_PER_SETTING = 45;
    localparam int N_SETTINGS = 6;

    typedef struct {
        logic [1:0]         channel;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [16:0] max_value;
        logic signed [8:0]  best_tap;
    } t_pixel_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [1:0]         i_out_channel;
    logic [1:0]         i_in_channel;
    logic [5:0]         i_row;
    logic [5:0]         i_col;
    logic signed [15:0] i_value;
    logic               o_done;
    logic [1:0]         o_result_channel;
    logic [5:0]         o_result_row;
    logic [5:0]         o_result_col;
    logic signed [16:0] o_max_value;
    logic signed [8:0]  o_best_tap;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    grayscale_dilation_argmax_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_out_channel    (i_out_channel),
        .i_in_channel     (i_in_channel),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_value          (i_value),
        .o_done           (o_done),
        .o_result_channel (o_result_channel),
        .o_result_row     (o_result_row),
        .o_result_col     (o_result_col),
        .o_max_value      (o_max_value),
        .o_best_tap       (o_best_tap),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Shadow copy of the block's registers and memories.
    int                 cfg_channels;
    int                 cfg_krows;
    int                 cfg_kcols;
    int                 cfg_irows;
    int                 cfg_icols;
    int                 cfg_orow;
    int                 cfg_ocol;
    logic signed [15:0] cfg_pad;
    logic signed [15:0] weight_mem [N_OUT * N_IN * N_KROW * N_KCOL];
    logic signed [15:0] image_mem [N_IN * N_IROW * N_ICOL];

    t_pixel_answer pending_answers[$];

    int idle_pct;
    int n_errors;
    int n_loads;
    int n_queries;
    int n_spare;
    int n_settings;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int saturate_size(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Scan in-channel, tap row, tap column; only a strictly greater sum
    // replaces the running maximum, so ties keep the earliest tap.
    function automatic t_pixel_answer dilate_pixel(input logic [1:0] oc,
                                                   input logic [5:0] r,
                                                   input logic [5:0] c);
        t_pixel_answer ans;
        int            best;
        int            tap;
        int            pr;
        int            pc;
        int            sum;
        best = int'(cfg_pad);
        tap  = -1;
        // The out_channel field cannot reach past the channel count here.
        if (int'(r) < cfg_irows && int'(c) < cfg_icols) begin
            for (int ci = 0; ci < cfg_channels; ci++) begin
                for (int kh = 0; kh < cfg_krows; kh++) begin
                    for (int kw = 0; kw < cfg_kcols; kw++) begin
                        pr = int'(r) + kh - cfg_orow;
                        pc = int'(c) + kw - cfg_ocol;
                        if (pr >= 0 && pr < cfg_irows && pc >= 0 && pc < cfg_icols) begin
                            sum = int'(image_mem[(ci * N_IROW + pr) * N_ICOL + pc])
                                + int'(weight_mem[((int'(oc) * N_IN + ci) * N_KROW + kh)
                                                  * N_KCOL + kw]);
                            if (sum > best) begin
                                best = sum;
                                tap  = ci * cfg_krows * cfg_kcols + kh * cfg_kcols + kw;
                            end
                        end
                    end
                end
            end
        end
        ans.channel   = oc;
        ans.row       = r;
        ans.col       = c;
        ans.max_value = best[16:0];
        ans.best_tap  = tap[8:0];
        return ans;
    endfunction

    function automatic void apply_request(input logic [1:0] cmd, input logic [1:0] oc,
                                          input logic [1:0] ic, input logic [5:0] r,
                                          input logic [5:0] c, input logic [15:0] value);
        case (cmd)
            gda_pkg::CMD_LOAD_WEIGHT: begin
                if (int'(r) < N_KROW && int'(c) < N_KCOL) begin
                    weight_mem[((int'(oc) * N_IN + int'(ic)) * N_KROW + int'(r)) * N_KCOL
                               + int'(c)] = value;
                    n_loads++;
                end
            end
            gda_pkg::CMD_LOAD_SAMPLE: begin
                image_mem[(int'(ic) * N_IROW + int'(r)) * N_ICOL + int'(c)] = value;
                n_loads++;
            end
            gda_pkg::CMD_QUERY: begin
                pending_answers.push_back(dilate_pixel(oc, r, c));
                n_queries++;
            end
            default: begin
                n_spare++;
            end
        endcase
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            gda_pkg::REG_CHANNELS_IN: cfg_channels = saturate_size(int'(data[2:0]), N_IN);
            gda_pkg::REG_KERNEL_ROWS: cfg_krows    = saturate_size(int'(data[3:0]), N_KROW);
            gda_pkg::REG_KERNEL_COLS: cfg_kcols    = saturate_size(int'(data[3:0]), N_KCOL);
            gda_pkg::REG_IMAGE_ROWS:  cfg_irows    = saturate_size(int'(data[6:0]), N_IROW);
            gda_pkg::REG_IMAGE_COLS:  cfg_icols    = saturate_size(int'(data[6:0]), N_ICOL);
            gda_pkg::REG_ORIGIN_ROW:  cfg_orow     = int'(data[2:0]);
            gda_pkg::REG_ORIGIN_COL:  cfg_ocol     = int'(data[2:0]);
            gda_pkg::REG_PAD_VALUE:   cfg_pad      = data[15:0];
            default: ;
        endcase
    endfunction

    // The sender may pause before raising start; start then stays high
    // until the request is taken.
    task automatic send_request(input logic [1:0] cmd, input logic [1:0] oc,
                                input logic [1:0] ic, input logic [5:0] r,
                                input logic [5:0] c, input logic [15:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_out_channel <= oc;
        i_in_channel  <= ic;
        i_row         <= r;
        i_col         <= c;
        i_value       <= value;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        apply_request(cmd, oc, ic, r, c, value);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() > 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        apply_register(idx, data);
    endtask

    task automatic set_config(input int ch, input int kr, input int kc, input int ir,
                              input int ic, input int orow, input int ocol,
                              input logic [15:0] pad);
        wait_quiet();
        apb_write(gda_pkg::REG_CHANNELS_IN, ch);
        apb_write(gda_pkg::REG_KERNEL_ROWS, kr);
        apb_write(gda_pkg::REG_KERNEL_COLS, kc);
        apb_write(gda_pkg::REG_IMAGE_ROWS, ir);
        apb_write(gda_pkg::REG_IMAGE_COLS, ic);
        apb_write(gda_pkg::REG_ORIGIN_ROW, orow);
        apb_write(gda_pkg::REG_ORIGIN_COL, ocol);
        apb_write(gda_pkg::REG_PAD_VALUE, {16'd0, pad});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // Every entry the random settings can make a query read is written here;
    // directed cases load the few extra entries they reach.
    task automatic test_fill_stores();
        idle_pct = 26;
        for (int oc = 0; oc < N_OUT; oc++) begin
            for (int ic = 0; ic < FILL_CH; ic++) begin
                for (int r = 0; r < FILL_K; r++) begin
                    for (int c = 0; c < FILL_K; c++) begin
                        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'(oc), 2'(ic), 6'(r), 6'(c),
                                     16'($urandom_range(0, 65535)));
                    end
                end
            end
        end
        for (int ic = 0; ic < FILL_CH; ic++) begin
            for (int r = 0; r < FILL_IMG; r++) begin
                for (int c = 0; c < FILL_IMG; c++) begin
                    send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'($urandom_range(0, 3)), 2'(ic),
                                 6'(r), 6'(c), 16'($urandom_range(0, 65535)));
                end
            end
        end
    endtask

    task automatic test_directed_cases();
        // Reset settings, opposite corners.
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd62, 6'd62, 16'h0123);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd62, 6'd63, 16'hFE00);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd63, 6'd62, 16'h0456);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd63, 6'd63, 16'h8000);
        send_request(gda_pkg::CMD_QUERY, 2'd0, 2'd0, 6'd0, 6'd0, 16'h0000);
        send_request(gda_pkg::CMD_QUERY, 2'd3, 2'd3, 6'd63, 6'd63, 16'hFFFF);

        // Two-tap kernel with the origin at the first tap: an exact tie.
        set_config(1, 1, 2, 64, 64, 0, 0, 16'h8000);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd10, 6'd20, 16'h0100);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd10, 6'd21, 16'h0100);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd1, 2'd0, 6'd0, 6'd0, 16'h0000);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd1, 2'd0, 6'd0, 6'd1, 16'h0000);
        send_request(gda_pkg::CMD_QUERY, 2'd1, 2'd0, 6'd10, 6'd20, 16'h0000);

        // Largest sum, and a second tap that falls off the right edge.
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd0, 6'd0, 16'h7FFF);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd0, 6'd0, 6'd63, 16'h0040);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd2, 2'd0, 6'd0, 6'd0, 16'h7FFF);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd2, 2'd0, 6'd0, 6'd1, 16'h8000);
        send_request(gda_pkg::CMD_QUERY, 2'd2, 2'd0, 6'd0, 6'd0, 16'h0000);
        send_request(gda_pkg::CMD_QUERY, 2'd2, 2'd0, 6'd0, 6'd63, 16'h0000);

        // Weight loads past the kernel size are dropped.
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd2, 2'd0, 6'd8, 6'd0, 16'h1234);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd3, 2'd3, 6'd63, 6'd63, 16'h7FFF);
        send_request(gda_pkg::CMD_QUERY, 2'd2, 2'd0, 6'd0, 6'd0, 16'h0000);

        // Smallest sum cannot beat the lowest pad.
        set_config(1, 1, 1, 64, 64, 0, 0, 16'h8000);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd3, 2'd0, 6'd5, 6'd5, 16'h8000);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd0, 2'd0, 6'd0, 6'd0, 16'h8000);
        send_request(gda_pkg::CMD_QUERY, 2'd0, 2'd0, 6'd5, 6'd5, 16'h0000);

        // Zero sizes act as one; the origin pushes every tap outside.
        set_config(0, 0, 0, 0, 0, 7, 7, 16'h7FFF);
        send_request(gda_pkg::CMD_QUERY, 2'd1, 2'd0, 6'd0, 6'd0, 16'h0000);
        send_request(gda_pkg::CMD_QUERY, 2'd1, 2'd0, 6'd1, 6'd0, 16'h0000);
        send_request(CMD_SPARE, 2'd3, 2'd3, 6'd63, 6'd63, 16'hFFFF);

        // Oversized settings saturate to the largest kernel; with the origin
        // at the far corner only the last tap of each channel lands on the
        // top-left pixel, and the last channel wins with the highest index.
        set_config(7, 15, 15, 127, 127, 7, 7, 16'h8000);
        send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'd0, 2'd3, 6'd0, 6'd0, 16'h7FFF);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd0, 2'd0, 6'd7, 6'd7, 16'h0000);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd0, 2'd1, 6'd7, 6'd7, 16'h0000);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd0, 2'd2, 6'd7, 6'd7, 16'h0000);
        send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'd0, 2'd3, 6'd7, 6'd7, 16'h7FFF);
        send_request(gda_pkg::CMD_QUERY, 2'd0, 2'd0, 6'd0, 6'd0, 16'h0000);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_random_traffic(input int setting);
        int          n_done;
        int          kind;
        logic [15:0] pad;
        idle_pct = (setting < 2) ? 26 : ((setting < 4) ? 50 : 0);
        pad = ($urandom_range(0, 3) == 0) ? 16'h8000 : pick_value();
        if (setting == 0) begin
            set_config(4, FILL_K, FILL_K, FILL_IMG, FILL_IMG, 0, 7, 16'h7FFF);
        end else if (setting == 1) begin
            set_config(1, 1, 1, 1, 1, 0, 0, 16'h8000);
        end else begin
            // Channel counts above the maximum saturate and stay inside the fill.
            set_config($urandom_range(0, 7), $urandom_range(0, FILL_K),
                       $urandom_range(0, FILL_K), $urandom_range(0, FILL_IMG),
                       $urandom_range(0, FILL_IMG), $urandom_range(0, 7),
                       $urandom_range(0, 7), pad);
        end
        n_done = 0;
        while (n_done < ITEMS_PER_SETTING) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_request(gda_pkg::CMD_QUERY, 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), 6'($urandom_range(0, cfg_irows - 1)),
                             6'($urandom_range(0, cfg_icols - 1)),
                             16'($urandom_range(0, 65535)));
                n_done++;
            end else if (kind < 48) begin
                send_request(gda_pkg::CMD_QUERY, 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
                n_done++;
            end else if (kind < 70) begin
                send_request(gda_pkg::CMD_LOAD_SAMPLE, 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), pick_value());
                n_done++;
            end else if (kind < 94) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'($urandom_range(0, 3)),
                                 2'($urandom_range(0, 3)), 6'($urandom_range(0, 7)),
                                 6'($urandom_range(0, 7)), pick_value());
                    n_done++;
                end else begin
                    // Mostly past the kernel size, hence dropped.
                    send_request(gda_pkg::CMD_LOAD_WEIGHT, 2'($urandom_range(0, 3)),
                                 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)), pick_value());
                end
            end else begin
                send_request(CMD_SPARE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             16'($urandom_range(0, 65535)));
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int expv, input int actv);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
        n_errors++;
    endtask

    // Results cannot be held off, so every strobe is checked as it comes.
    always @(posedge i_clk) begin
        t_pixel_answer exp_ans;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with no query outstanding, channel %0d row %0d col %0d",
                         $time, o_result_channel, o_result_row, o_result_col);
                n_errors++;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (o_result_channel !== exp_ans.channel) begin
                    report_mismatch("result_channel", int'(exp_ans.channel),
                                    int'(o_result_channel));
                end
                if (o_result_row !== exp_ans.row) begin
                    report_mismatch("result_row", int'(exp_ans.row), int'(o_result_row));
                end
                if (o_result_col !== exp_ans.col) begin
                    report_mismatch("result_col", int'(exp_ans.col), int'(o_result_col));
                end
                if (o_max_value !== exp_ans.max_value) begin
                    report_mismatch("max_value", int'(exp_ans.max_value), int'(o_max_value));
                end
                if (o_best_tap !== exp_ans.best_tap) begin
                    report_mismatch("best_tap", int'(exp_ans.best_tap), int'(o_best_tap));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= gda_pkg::CMD_LOAD_WEIGHT;
        i_out_channel <= 2'd0;
        i_in_channel  <= 2'd0;
        i_row         <= 6'd0;
        i_col         <= 6'd0;
        i_value       <= 16'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 5'd0;
        pwdata        <= 32'd0;
        n_errors      = 0;
        n_loads       = 0;
        n_queries     = 0;
        n_spare       = 0;
        n_settings    = 0;
        idle_pct      = 0;
        cfg_channels  = int'(gda_pkg::RST_CHANNELS_IN);
        cfg_krows     = int'(gda_pkg::RST_KERNEL_ROWS);
        cfg_kcols     = int'(gda_pkg::RST_KERNEL_COLS);
        cfg_irows     = int'(gda_pkg::RST_IMAGE_ROWS);
        cfg_icols     = int'(gda_pkg::RST_IMAGE_COLS);
        cfg_orow      = int'(gda_pkg::RST_ORIGIN_ROW);
        cfg_ocol      = int'(gda_pkg::RST_ORIGIN_COL);
        cfg_pad       = gda_pkg::RST_PAD_VALUE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_stores();
        test_directed_cases();
        for (int s = 0; s < N_SETTINGS; s++) begin
            test_random_traffic(s);
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_answers.size() > 0) begin
            $display("%0t: %0d query answers never arrived", $time, pending_answers.size());
            n_errors++;
        end
        $display("Run covered %0d memory loads, %0d queries and %0d spare commands", n_loads,
                 n_queries, n_spare);
        $display("over %0d register settings, with %0d mismatches", n_settings, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
